// ----- design/running_sum_mean_stddev_peak_macros.svh -----
`ifndef RUNNING_SUM_MEAN_STDDEV_PEAK_MACROS_SVH
`define RUNNING_SUM_MEAN_STDDEV_PEAK_MACROS_SVH

// same-cycle implication, checked outside reset
`define RSMSP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define RSMSP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/rsmsp_pkg.sv -----
`default_nettype none

package rsmsp_pkg;

    // input word kinds (tuser)
    localparam logic OP_ADD    = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    // shared restoring divider
    localparam int DIV_NUM_W = 80;
    localparam int DIV_DEN_W = 33;
    localparam int DIV_CNT_W = $clog2(DIV_NUM_W);
    localparam int QUOT_W    = 48;

    // digit-by-digit square root
    localparam int SQ_IN_W   = 48;
    localparam int SQ_OUT_W  = SQ_IN_W / 2;
    localparam int SQ_REM_W  = SQ_OUT_W + 2;
    localparam int SQ_CNT_W  = $clog2(SQ_OUT_W);

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic                start;
        logic [SQ_IN_W-1:0]  val;
    } t_sq_req;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MB,
        S_MALO,
        S_MAHI,
        S_MNN,
        S_DIFF,
        S_DDIV_GO,
        S_DDIV_WAIT,
        S_SQ_GO,
        S_SQ_WAIT,
        S_MDIV_GO,
        S_MDIV_WAIT,
        S_OUT
    } t_state;

endpackage

`default_nettype wire

// ----- design/rsmsp_div.sv -----
`default_nettype none

module rsmsp_div import rsmsp_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_div_req          i_req,
    output logic                   o_done,
    output logic [QUOT_W-1:0]      o_quot
);

    localparam logic [DIV_CNT_W-1:0] LAST_STEP = DIV_CNT_W'(DIV_NUM_W - 1);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_DEN_W-1:0] r_rem;
    logic [DIV_DEN_W-1:0] r_den;
    logic [DIV_NUM_W-1:0] r_num;

    logic [DIV_DEN_W:0]   w_shift;
    logic [DIV_DEN_W:0]   w_diff;
    logic                 w_ge;
    logic [DIV_DEN_W-1:0] n_rem;

    // one quotient bit a cycle; quotient bits shift into the numerator register
    always_comb begin
        w_shift = {r_rem, r_num[DIV_NUM_W-1]};
        w_ge    = w_shift >= {1'b0, r_den};
        w_diff  = w_shift - {1'b0, r_den};
        n_rem   = w_ge ? w_diff[DIV_DEN_W-1:0] : w_shift[DIV_DEN_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num <= i_req.num;
            r_den <= i_req.den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[DIV_NUM_W-2:0], w_ge};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_num[QUOT_W-1:0];

endmodule

`default_nettype wire

// ----- design/rsmsp_isqrt.sv -----
`default_nettype none

module rsmsp_isqrt import rsmsp_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_sq_req           i_req,
    output logic                   o_done,
    output logic [SQ_OUT_W-1:0]    o_root
);

    localparam logic [SQ_CNT_W-1:0] LAST_STEP = SQ_CNT_W'(SQ_OUT_W - 1);

    logic                r_busy;
    logic                r_done;
    logic [SQ_CNT_W-1:0] r_cnt;
    logic [SQ_IN_W-1:0]  r_x;
    logic [SQ_REM_W-1:0] r_rem;
    logic [SQ_OUT_W-1:0] r_root;

    logic [SQ_REM_W+1:0] w_rem_sh;
    logic [SQ_REM_W+1:0] w_trial;
    logic [SQ_REM_W+1:0] w_diff;
    logic                w_ge;
    logic [SQ_REM_W-1:0] n_rem;

    // one root bit a cycle: bring down two radicand bits, try 4*root+1
    always_comb begin
        w_rem_sh = {r_rem, r_x[SQ_IN_W-1 -: 2]};
        w_trial  = {2'b00, r_root, 2'b01};
        w_ge     = w_rem_sh >= w_trial;
        w_diff   = w_rem_sh - w_trial;
        n_rem    = w_ge ? w_diff[SQ_REM_W-1:0] : w_rem_sh[SQ_REM_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_x    <= i_req.val;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_x    <= {r_x[SQ_IN_W-3:0], 2'b00};
            r_rem  <= n_rem;
            r_root <= {r_root[SQ_OUT_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

`default_nettype wire

// ----- design/running_sum_mean_stddev_peak.sv -----
// Running sum, Q.8 mean, Q.8 population standard deviation and peak index.
// Input stream (i_s_*): tuser selects the word kind, 0 adds the sample in
// tdata, 1 finishes the set. Sample words are taken one per cycle while idle
// and yield no output. A finish word yields one output word (o_m_*) and
// clears all running state.
// The result word of an empty set goes from its finish word straight to the
// output stage. Any other finish runs four passes through the shared 32x32
// multiplier, two 80-step passes through the shared restoring divider
// (variance, then mean) and a 24-step square root, one bit per cycle each,
// with sequencing states between them. The input is not ready during that
// sequence, so a new set cannot finish before the last one is through.
// The output register holds a finished word while the receiver stalls;
// samples are still accepted meanwhile, and a following finish runs its
// sequence but waits at the end until the register is free.
// Samples beyond MAX_SAMPLES are dropped and flagged in the next output word.
// Reset (synchronous, active low) clears all running state and empties the
// output register.
`default_nettype none
`include "running_sum_mean_stddev_peak_macros.svh"

module running_sum_mean_stddev_peak import rsmsp_pkg::*; #(
    parameter int MAX_SAMPLES = 65536
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    input  wire logic [15:0]  i_s_tdata,   // [15:0] sample
    input  wire logic         i_s_tuser,   // [0] op
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    output logic [119:0]      o_m_tdata    // [31:0] total, [55:32] mean_q8,
                                           // [79:56] std_dev_q8,
                                           // [95:80] peak_position,
                                           // [112:96] sample_count,
                                           // [113] overflowed, [119:114] zero
);

    localparam logic [16:0] MAX_CNT = 17'(MAX_SAMPLES);

    t_state               r_state;
    t_state               n_state;

    logic signed [31:0]   r_sum;
    logic [46:0]          r_sumsq;
    logic [30:0]          r_sq_pend;
    logic                 r_sq_vld;
    logic signed [15:0]   r_peak_val;
    logic [15:0]          r_peak_idx;
    logic [16:0]          r_count;
    logic                 r_drop;

    logic [63:0]          r_prod;
    logic [63:0]          r_a;
    logic [63:0]          r_b;
    logic [63:0]          r_d;
    logic [32:0]          r_n2;
    logic [QUOT_W-1:0]    r_v;
    logic [23:0]          r_mean;
    logic [23:0]          r_dev;

    logic                 r_m_valid;
    logic [119:0]         r_m_data;

    logic                 w_s_acc;
    logic                 w_add;
    logic                 w_fin;
    logic                 w_out_load;
    logic signed [15:0]   w_sample;
    logic signed [31:0]   w_sq;
    logic [31:0]          w_mag;
    logic [31:0]          w_mul_a;
    logic [31:0]          w_mul_b;

    t_div_req             w_div_req;
    logic                 w_div_done;
    logic [QUOT_W-1:0]    w_div_quot;
    t_sq_req              w_sq_req;
    logic                 w_sq_done;
    logic [SQ_OUT_W-1:0]  w_root;

    assign o_s_tready = (r_state == S_IDLE);
    assign w_s_acc    = i_s_tvalid && o_s_tready;
    assign w_add      = w_s_acc && (i_s_tuser == OP_ADD);
    assign w_fin      = w_s_acc && (i_s_tuser == OP_FINISH);
    assign w_out_load = (r_state == S_OUT) && (!r_m_valid || i_m_tready);
    assign w_sample   = $signed(i_s_tdata);
    assign w_sq       = w_sample * w_sample;
    assign w_mag      = r_sum[31] ? (~r_sum + 32'd1) : r_sum;

    // ---------------- accumulation ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_out_load) begin
            r_sum      <= '0;
            r_sumsq    <= '0;
            r_sq_vld   <= 1'b0;
            r_peak_val <= '0;
            r_peak_idx <= '0;
            r_count    <= '0;
            r_drop     <= 1'b0;
        end else begin
            // squares go through one register stage before the add
            if (r_sq_vld) begin
                r_sumsq <= r_sumsq + {16'd0, r_sq_pend};
            end
            r_sq_vld <= 1'b0;
            if (w_add) begin
                if (r_count == MAX_CNT) begin
                    r_drop <= 1'b1;
                end else begin
                    r_sum    <= r_sum + {{16{w_sample[15]}}, w_sample};
                    r_sq_vld <= 1'b1;
                    r_count  <= r_count + 17'd1;
                    if (w_sample > r_peak_val) begin
                        r_peak_val <= w_sample;
                        r_peak_idx <= r_count[15:0];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sq_pend <= w_sq[30:0];
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_fin) begin
                    n_state = (r_count == '0) ? S_OUT : S_MB;
                end
            end
            S_MB:        n_state = S_MALO;
            S_MALO:      n_state = S_MAHI;
            S_MAHI:      n_state = S_MNN;
            S_MNN:       n_state = S_DIFF;
            S_DIFF:      n_state = S_DDIV_GO;
            S_DDIV_GO:   n_state = S_DDIV_WAIT;
            S_DDIV_WAIT: begin
                if (w_div_done) begin
                    n_state = S_SQ_GO;
                end
            end
            S_SQ_GO:     n_state = S_SQ_WAIT;
            S_SQ_WAIT: begin
                if (w_sq_done) begin
                    n_state = S_MDIV_GO;
                end
            end
            S_MDIV_GO:   n_state = S_MDIV_WAIT;
            S_MDIV_WAIT: begin
                if (w_div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default:     n_state = S_IDLE;
        endcase
    end

    // shared multiplier operands
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (r_state)
            S_MB: begin
                w_mul_a = w_mag;
                w_mul_b = w_mag;
            end
            S_MALO: begin
                w_mul_a = {15'd0, r_count};
                w_mul_b = {8'd0, r_sumsq[23:0]};
            end
            S_MAHI: begin
                w_mul_a = {15'd0, r_count};
                w_mul_b = {9'd0, r_sumsq[46:24]};
            end
            S_MNN: begin
                w_mul_a = {15'd0, r_count};
                w_mul_b = {15'd0, r_count};
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    always_comb begin
        w_div_req.start = (r_state == S_DDIV_GO) || (r_state == S_MDIV_GO);
        if (r_state == S_MDIV_GO) begin
            w_div_req.num = {40'd0, w_mag, 8'd0};
            w_div_req.den = {16'd0, r_count};
        end else begin
            w_div_req.num = {r_d, 16'd0};
            w_div_req.den = r_n2;
        end
        w_sq_req.start = (r_state == S_SQ_GO);
        w_sq_req.val   = r_v;
    end

    // datapath: products, variance numerator and results
    always_ff @(posedge i_clk) begin
        r_prod <= w_mul_a * w_mul_b;
        case (r_state)
            S_IDLE: begin
                // empty set reports zero mean and deviation
                if (w_fin) begin
                    r_mean <= '0;
                    r_dev  <= '0;
                end
            end
            S_MALO:      r_b <= r_prod;
            S_MAHI:      r_a <= r_prod;
            S_MNN:       r_a <= r_a + {r_prod[39:0], 24'd0};
            S_DIFF: begin
                r_n2 <= r_prod[32:0];
                r_d  <= (r_a > r_b) ? (r_a - r_b) : '0;
            end
            S_DDIV_WAIT: begin
                if (w_div_done) begin
                    r_v <= w_div_quot;
                end
            end
            S_SQ_WAIT: begin
                if (w_sq_done) begin
                    r_dev <= w_root;
                end
            end
            S_MDIV_WAIT: begin
                // truncate toward zero: divide magnitudes, then restore sign
                if (w_div_done) begin
                    r_mean <= r_sum[31] ? (~w_div_quot[23:0] + 24'd1) : w_div_quot[23:0];
                end
            end
            default: begin
            end
        endcase
    end

    rsmsp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_done  (w_div_done),
        .o_quot  (w_div_quot)
    );

    rsmsp_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_sq_req),
        .o_done  (w_sq_done),
        .o_root  (w_root)
    );

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_out_load) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_m_data <= {6'd0, r_drop, r_count, r_peak_idx, r_dev, r_mean, r_sum};
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;

    // ---------------- checks ----------------
    `RSMSP_ASSERT_IMP(a_busy_not_ready, i_clk, i_rst_n,
        (r_state != S_IDLE), !o_s_tready, "input ready while finishing a set")
    `RSMSP_ASSERT_IMP(a_count_bound, i_clk, i_rst_n,
        1'b1, (r_count <= MAX_CNT), "sample count beyond capacity")
    `RSMSP_ASSERT_NXT(a_finish_leaves_idle, i_clk, i_rst_n,
        w_fin, (r_state != S_IDLE), "finish word did not start the sequence")
    `RSMSP_ASSERT_NXT(a_load_clears, i_clk, i_rst_n,
        w_out_load, (o_m_tvalid && (r_count == '0) && !r_drop),
        "result load did not present the word and clear the state")

endmodule

`default_nettype wire
